// ===== rtl/core/swlrl_pkg.sv =====
package swlrl_pkg;

  localparam int RING_DEPTH = 64;
  localparam int IDX_W      = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
  localparam int CNT_W      = $clog2(RING_DEPTH + 1);

  localparam int STAMP_W  = 32;
  localparam int MAXREQ_W = 7;
  localparam int WINDOW_W = 31;
  localparam int REMAIN_W = 7;
  localparam int RETRY_W  = 31;
  localparam int CFG_IDX_W  = 8;
  localparam int CFG_DATA_W = 32;

  localparam logic [MAXREQ_W-1:0] MAXREQ_RESET = MAXREQ_W'(10);
  localparam logic [WINDOW_W-1:0] WINDOW_RESET = WINDOW_W'(1000);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MAX_REQUESTS = 8'd0,
    CFG_WINDOW_MS    = 8'd1
  } cfg_idx_e;

  typedef enum logic {
    ST_IDLE,
    ST_CHECK
  } ctrl_state_e;

  typedef struct packed {
    logic               rd_en;
    logic [IDX_W-1:0]   rd_addr;
    logic               wr_en;
    logic [IDX_W-1:0]   wr_addr;
    logic [STAMP_W-1:0] wr_data;
  } mem_req_t;

endpackage

// ===== rtl/core/swlrl_if.sv =====
interface swlrl_req_if;
  import swlrl_pkg::*;
  logic               valid;
  logic               ready;
  logic [STAMP_W-1:0] now_ms;
  modport source (output valid, output now_ms, input ready);
  modport sink   (input valid, input now_ms, output ready);
endinterface

interface swlrl_rsp_if;
  import swlrl_pkg::*;
  logic                valid;
  logic                ready;
  logic                allowed;
  logic [REMAIN_W-1:0] remaining;
  logic [RETRY_W-1:0]  retry_after_ms;
  modport source (output valid, output allowed, output remaining, output retry_after_ms,
                  input ready);
  modport sink   (input valid, input allowed, input remaining, input retry_after_ms,
                  output ready);
endinterface

interface swlrl_cfg_if;
  import swlrl_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== rtl/core/swlrl_ring_mem.sv =====
module swlrl_ring_mem (
  input  logic                       clk_i,
  input  swlrl_pkg::mem_req_t        mem_req_i,
  output logic [swlrl_pkg::STAMP_W-1:0] rd_data_o
);
  import swlrl_pkg::*;

  logic [STAMP_W-1:0] ring_mem [RING_DEPTH];
  logic [STAMP_W-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (mem_req_i.wr_en) begin
      ring_mem[mem_req_i.wr_addr] <= mem_req_i.wr_data;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_req_i.rd_en) begin
      rd_data_q <= ring_mem[mem_req_i.rd_addr];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

// ===== rtl/core/swlrl_ctrl.sv =====
module swlrl_ctrl (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  swlrl_req_if.sink                      req_i,
  swlrl_rsp_if.source                    rsp_o,
  input  logic [swlrl_pkg::MAXREQ_W-1:0] max_req_i,
  input  logic [swlrl_pkg::WINDOW_W-1:0] window_i,
  output swlrl_pkg::mem_req_t            mem_req_o,
  input  logic [swlrl_pkg::STAMP_W-1:0]  rd_data_i
);
  import swlrl_pkg::*;

  ctrl_state_e          state_q, state_d;
  logic [IDX_W-1:0]     head_q;
  logic [CNT_W-1:0]     count_q;
  logic [STAMP_W-1:0]   now_q;
  logic                 out_valid_q;
  logic                 allowed_q;
  logic [REMAIN_W-1:0]  remaining_q;
  logic [RETRY_W-1:0]   retry_q;

  logic [STAMP_W-1:0]   age;
  logic                 expire;
  logic                 out_free;
  logic                 finish;
  logic                 admit;
  logic [CNT_W-1:0]     limit;
  logic [IDX_W-1:0]     head_inc;
  logic [CNT_W:0]       tail_sum;
  logic [IDX_W-1:0]     tail;
  logic                 req_fire;

  assign req_fire = req_i.valid && req_i.ready;
  assign age      = now_q - rd_data_i;
  assign expire   = (state_q == ST_CHECK) && (count_q != '0)
                    && (age >= {1'b0, window_i});
  assign out_free = !out_valid_q || rsp_o.ready;
  assign finish   = (state_q == ST_CHECK) && !expire && out_free;
  assign limit    = (32'(max_req_i) > RING_DEPTH) ? CNT_W'(RING_DEPTH) : CNT_W'(max_req_i);
  assign admit    = count_q < limit;
  assign head_inc = (head_q == IDX_W'(RING_DEPTH - 1)) ? '0 : head_q + IDX_W'(1);
  assign tail_sum = (CNT_W+1)'(head_q) + (CNT_W+1)'(count_q);
  assign tail     = (tail_sum >= (CNT_W+1)'(RING_DEPTH))
                    ? IDX_W'(tail_sum - (CNT_W+1)'(RING_DEPTH)) : IDX_W'(tail_sum);

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:  if (req_i.valid) state_d = ST_CHECK;
      ST_CHECK: if (finish) state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    req_i.ready       = 1'b0;
    mem_req_o         = '0;
    mem_req_o.wr_addr = tail;
    mem_req_o.wr_data = now_q;
    mem_req_o.rd_addr = head_q;
    unique case (state_q)
      ST_IDLE: begin
        req_i.ready     = 1'b1;
        mem_req_o.rd_en = req_i.valid;
      end
      ST_CHECK: begin
        // expired head: pop it and fetch the next one
        mem_req_o.rd_en   = expire;
        mem_req_o.rd_addr = head_inc;
        mem_req_o.wr_en   = finish && admit;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      head_q      <= '0;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (expire) begin
        head_q  <= head_inc;
        count_q <= count_q - CNT_W'(1);
      end else if (finish && admit) begin
        count_q <= count_q + CNT_W'(1);
      end
      if (finish) begin
        out_valid_q <= 1'b1;
      end else if (rsp_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_fire) begin
      now_q <= req_i.now_ms;
    end
    if (finish) begin
      allowed_q   <= admit;
      remaining_q <= admit ? REMAIN_W'(limit - count_q - CNT_W'(1)) : '0;
      retry_q     <= (!admit && count_q != '0) ? window_i - age[RETRY_W-1:0] : '0;
    end
  end

  assign rsp_o.valid          = out_valid_q;
  assign rsp_o.allowed        = allowed_q;
  assign rsp_o.remaining      = remaining_q;
  assign rsp_o.retry_after_ms = retry_q;

endmodule

// ===== rtl/core/sliding_window_log_rate_limiter_core.sv =====
// channel | dir | fields                              | beat when
// req_i   | in  | now_ms[31:0]                        | valid && ready
// rsp_o   | out | allowed, remaining[6:0], retry[30:0] | valid && ready
// cfg_i   | in  | index[7:0], data[31:0]              | valid && ready (always ready)
//
// a request reads the oldest ring entry, then pops every expired entry from the ring;
// each pop is one registered read of the timestamp ram (separate read and write ports).
// reset empties the ring at once (head and count cleared), no clearing pass.
// a finished result sits in the output register; a stalled rsp_o holds the
// next request in the check state until the register frees.
module sliding_window_log_rate_limiter_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  swlrl_req_if.sink   req_i,
  swlrl_rsp_if.source rsp_o,
  swlrl_cfg_if.sink   cfg_i
);
  import swlrl_pkg::*;

  logic [MAXREQ_W-1:0] max_req_q;
  logic [WINDOW_W-1:0] window_q;
  mem_req_t            mem_req;
  logic [STAMP_W-1:0]  rd_data;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_req_q <= MAXREQ_RESET;
      window_q  <= WINDOW_RESET;
    end else if (cfg_i.valid) begin
      unique case (cfg_i.index)
        CFG_MAX_REQUESTS: max_req_q <= cfg_i.data[MAXREQ_W-1:0];
        CFG_WINDOW_MS:    window_q  <= cfg_i.data[WINDOW_W-1:0];
        default: ;
      endcase
    end
  end

  swlrl_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .req_i     (req_i),
    .rsp_o     (rsp_o),
    .max_req_i (max_req_q),
    .window_i  (window_q),
    .mem_req_o (mem_req),
    .rd_data_i (rd_data)
  );

  swlrl_ring_mem u_ring_mem (
    .clk_i     (clk_i),
    .mem_req_i (mem_req),
    .rd_data_o (rd_data)
  );

endmodule

// ===== rtl/core/swlrl_checker.sv =====
module swlrl_checker (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           req_valid_i,
  input logic                           req_ready_i,
  input logic                           rsp_valid_i,
  input logic                           rsp_ready_i,
  input logic                           rsp_allowed_i,
  input logic [swlrl_pkg::REMAIN_W-1:0] rsp_remaining_i,
  input logic [swlrl_pkg::RETRY_W-1:0]  rsp_retry_i
);
  import swlrl_pkg::*;

  a_rsp_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && !rsp_ready_i |=> rsp_valid_i && $stable(rsp_allowed_i)
      && $stable(rsp_remaining_i) && $stable(rsp_retry_i))
    else $error("stalled result changed");

  a_reject_no_slots: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && !rsp_allowed_i |-> rsp_remaining_i == '0)
    else $error("rejected beat reports free slots");

  a_accept_no_retry: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && rsp_allowed_i |-> rsp_retry_i == '0)
    else $error("accepted beat reports retry time");

  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_valid_i && req_ready_i |=> !req_ready_i)
    else $error("request taken while previous one in flight");

endmodule

bind sliding_window_log_rate_limiter_core swlrl_checker u_swlrl_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .req_valid_i     (req_i.valid),
  .req_ready_i     (req_i.ready),
  .rsp_valid_i     (rsp_o.valid),
  .rsp_ready_i     (rsp_o.ready),
  .rsp_allowed_i   (rsp_o.allowed),
  .rsp_remaining_i (rsp_o.remaining),
  .rsp_retry_i     (rsp_o.retry_after_ms)
);
